FILE: rtl/assert_macros.svh
// Assertion macros for the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPL(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition");
`else
`define ASSERT_IMPL(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, cond)
`endif
`endif

FILE: rtl/sscc_pkg.sv
package sscc_pkg;
    localparam int MAX_VARIANTS_DEF  = 4;
    localparam int MAX_CYCLES_DEF    = 64;
    localparam int MAX_ROW_BYTES_DEF = 1024;
    localparam int MAX_SIGNALS_DEF   = 1024;
    localparam int MASK_W            = 4;

    localparam logic [1:0] REG_SLOT_COUNT    = 2'd0;
    localparam logic [1:0] REG_SLOT_LENGTH   = 2'd1;
    localparam logic [1:0] REG_HYPER_PERIOD  = 2'd2;
    localparam logic [1:0] REG_VARIANT_COUNT = 2'd3;

    localparam logic FUNC_PLACE = 1'b0;
    localparam logic FUNC_CLEAR = 1'b1;

    typedef struct packed {
        logic        func;
        logic [9:0]  signal_id;
        logic [7:0]  start_cycle;
        logic [6:0]  period;
        logic [9:0]  slot_index;
        logic [9:0]  frame_offset;
        logic [7:0]  byte_length;
        logic [3:0]  variant_mask;
    } item_t;

    typedef struct packed {
        logic        collision;
        logic [9:0]  first_occupant;
        logic [15:0] collision_bytes;
        logic        start_out_of_range;
        logic        frame_out_of_range;
        logic        period_invalid;
        logic        schedule_failed;
    } result_t;

    typedef struct packed {
        logic [9:0] slot_count;
        logic [7:0] slot_length;
        logic [6:0] hyper_period;
        logic [2:0] variant_count;
    } cfg_t;

    // decoded job handed from the front to the back
    typedef struct packed {
        logic        clear;
        logic        skip;     // nothing to place
        logic        per_inv;
        logic [10:0] tag;      // signal id plus one
        logic [8:0]  cyc;      // first cycle, signed
        logic [6:0]  period;
        logic [6:0]  reps;
        logic [6:0]  hp;
        logic [17:0] pos0;     // first byte position
        logic [7:0]  len;
        logic [16:0] row;
        logic [3:0]  vmask;    // mask already limited to the variant count
    } job_t;
endpackage

FILE: rtl/sscc_if.sv
interface sscc_item_if;
    import sscc_pkg::*;
    logic  valid;
    logic  ready;
    item_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface sscc_result_if;
    import sscc_pkg::*;
    logic    valid;
    logic    ready;
    result_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface sscc_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] index;
    logic [9:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

FILE: rtl/sscc_front.sv
// Classifies an item and works out the loop bounds; reps uses a serial divider.
module sscc_front
    import sscc_pkg::*;
#(
    parameter int MAX_VARIANTS  = MAX_VARIANTS_DEF,
    parameter int MAX_CYCLES    = MAX_CYCLES_DEF,
    parameter int MAX_ROW_BYTES = MAX_ROW_BYTES_DEF
) (
    input  logic  clk,
    input  logic  rst_n,
    input  cfg_t  cfg,
    input  logic  in_valid,
    output logic  in_ready,
    input  item_t in_data,
    output logic  job_valid,
    input  logic  job_ready,
    output job_t  job
);
    typedef enum logic [2:0] {
        F_IDLE = 3'b001,
        F_DIV  = 3'b010,
        F_OUT  = 3'b100
    } fstate_t;

    fstate_t     state_reg, state_next;
    job_t        job_reg, job_next;
    logic [2:0]  step_reg, step_next;
    logic [6:0]  rem_reg, rem_next;
    logic [17:0] prod;
    logic [17:0] row_full;
    logic [3:0]  vlim;
    logic [4:0]  nv;
    logic [7:0]  trial;

    always_comb
    begin
        prod     = 18'(in_data.slot_index) * 18'(cfg.slot_length);
        row_full = 18'(cfg.slot_count) * 18'(cfg.slot_length);
        nv = (5'(cfg.variant_count) < 5'(MAX_VARIANTS)) ? 5'(cfg.variant_count)
                                                        : 5'(MAX_VARIANTS);
        for (int i = 0; i < MASK_W; i++)
        begin
            vlim[i] = (5'(i) < nv);
        end
        trial = {rem_reg, job_reg.reps[6]};
    end

    always_comb
    begin
        state_next = state_reg;
        job_next   = job_reg;
        step_next  = step_reg;
        rem_next   = rem_reg;
        case (state_reg)
            F_IDLE:
            begin
                if (in_valid)
                begin
                    job_next.clear   = (in_data.func == FUNC_CLEAR);
                    job_next.per_inv = (in_data.func == FUNC_PLACE) &&
                                       (in_data.period == 7'd0) && (cfg.slot_count != 10'd0);
                    job_next.skip    = (cfg.slot_count == 10'd0) || (in_data.period == 7'd0);
                    job_next.tag     = 11'(in_data.signal_id) + 11'd1;
                    job_next.cyc     = {in_data.start_cycle[7], in_data.start_cycle};
                    job_next.period  = in_data.period;
                    job_next.reps    = cfg.hyper_period;   // dividend, shifted out
                    job_next.hp      = (7'(cfg.hyper_period) < 7'(MAX_CYCLES))
                                       ? cfg.hyper_period : 7'(MAX_CYCLES);
                    job_next.pos0    = prod + 18'(in_data.frame_offset);
                    job_next.len     = in_data.byte_length;
                    job_next.row     = (row_full > 18'(MAX_ROW_BYTES)) ? 17'(MAX_ROW_BYTES)
                                                                    : row_full[16:0];
                    job_next.vmask   = in_data.variant_mask & vlim;
                    rem_next  = 7'd0;
                    step_next = 3'd0;
                    state_next = (in_data.func == FUNC_CLEAR || in_data.period == 7'd0)
                                 ? F_OUT : F_DIV;
                end
            end
            F_DIV:
            begin
                if (trial >= {1'b0, job_reg.period})
                begin
                    rem_next = 7'(trial - {1'b0, job_reg.period});
                    job_next.reps = {job_reg.reps[5:0], 1'b1};
                end
                else
                begin
                    rem_next = trial[6:0];
                    job_next.reps = {job_reg.reps[5:0], 1'b0};
                end
                step_next = step_reg + 3'd1;
                if (step_reg == 3'd6)
                begin
                    state_next = F_OUT;
                end
            end
            F_OUT:
            begin
                if (job_ready)
                begin
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            step_reg  <= 3'd0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg <= job_next;
        rem_reg <= rem_next;
    end

    assign in_ready  = (state_reg == F_IDLE);
    assign job_valid = (state_reg == F_OUT);
    assign job       = job_reg;
endmodule

FILE: rtl/sscc_back.sv
// Walks repetitions, bytes and variants through the store.
// The store is cleared by a sweep, also after reset.
`include "assert_macros.svh"
module sscc_back
    import sscc_pkg::*;
#(
    parameter int MAX_VARIANTS  = MAX_VARIANTS_DEF,
    parameter int MAX_CYCLES    = MAX_CYCLES_DEF,
    parameter int MAX_ROW_BYTES = MAX_ROW_BYTES_DEF
) (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    job_valid,
    output logic    job_ready,
    input  job_t    job,
    output logic    res_valid,
    input  logic    res_ready,
    output result_t res
);
    localparam int VW    = (MAX_VARIANTS > 1) ? $clog2(MAX_VARIANTS) : 1;
    localparam int CW    = (MAX_CYCLES > 1) ? $clog2(MAX_CYCLES) : 1;
    localparam int BW    = $clog2(MAX_ROW_BYTES);
    localparam int AW    = VW + CW + BW;
    localparam int DEPTH = MAX_VARIANTS * (2 ** (CW + BW));

    typedef enum logic [6:0] {
        B_CLR  = 7'b0000001,
        B_IDLE = 7'b0000010,
        B_REP  = 7'b0000100,
        B_BYTE = 7'b0001000,
        B_READ = 7'b0010000,
        B_CHK  = 7'b0100000,
        B_OUT  = 7'b1000000
    } bstate_t;

    logic [10:0] mem [DEPTH];

    bstate_t     state_reg, state_next;
    job_t        job_reg, job_next;
    result_t     res_reg, res_next;
    logic        failed_reg, failed_next;
    logic [AW:0] clr_reg, clr_next;
    logic [6:0]  j_reg, j_next;
    logic [8:0]  cyc_reg, cyc_next;
    logic [7:0]  k_reg, k_next;
    logic [17:0] pos_reg, pos_next;
    logic [4:0]  l_reg, l_next;
    logic        we;
    logic [AW-1:0] waddr, raddr;
    logic [10:0] wdata, rdata_reg;

    always_comb
    begin
        state_next  = state_reg;
        job_next    = job_reg;
        res_next    = res_reg;
        failed_next = failed_reg;
        clr_next    = clr_reg;
        j_next      = j_reg;
        cyc_next    = cyc_reg;
        k_next      = k_reg;
        pos_next    = pos_reg;
        l_next      = l_reg;
        we    = 1'b0;
        waddr = clr_reg[AW-1:0];
        wdata = 11'd0;
        raddr = {l_reg[VW-1:0], cyc_reg[CW-1:0], pos_reg[BW-1:0]};
        case (state_reg)
            B_CLR:
            begin
                we = (clr_reg < (AW+1)'(DEPTH));
                clr_next = clr_reg + (AW+1)'(1);
                if (clr_reg >= (AW+1)'(DEPTH - 1))
                begin
                    state_next = (job_reg.clear) ? B_OUT : B_IDLE;
                end
            end
            B_IDLE:
            begin
                if (job_valid)
                begin
                    job_next = job;
                    res_next = '0;
                    res_next.period_invalid = job.per_inv;
                    j_next   = 7'd0;
                    cyc_next = job.cyc;
                    if (job.clear)
                    begin
                        failed_next = 1'b0;
                        clr_next = '0;
                        state_next = B_CLR;
                    end
                    else if (job.skip)
                    begin
                        state_next = B_OUT;
                    end
                    else
                    begin
                        state_next = B_REP;
                    end
                end
            end
            B_REP:
            begin
                k_next   = 8'd0;
                pos_next = job_reg.pos0;
                if (j_reg >= job_reg.reps)
                begin
                    state_next = B_OUT;
                end
                else if (cyc_reg[8] || cyc_reg >= {2'b00, job_reg.hp})
                begin
                    res_next.start_out_of_range = 1'b1;
                    j_next   = j_reg + 7'd1;
                    cyc_next = cyc_reg + 9'(job_reg.period);
                end
                else
                begin
                    state_next = B_BYTE;
                end
            end
            B_BYTE:
            begin
                l_next = 5'd0;
                if (k_reg >= job_reg.len)
                begin
                    j_next   = j_reg + 7'd1;
                    cyc_next = cyc_reg + 9'(job_reg.period);
                    state_next = B_REP;
                end
                else if (pos_reg >= 18'(job_reg.row))
                begin
                    res_next.frame_out_of_range = 1'b1;
                    k_next   = k_reg + 8'd1;
                    pos_next = pos_reg + 18'd1;
                end
                else
                begin
                    state_next = B_READ;
                end
            end
            B_READ:
            begin
                if (l_reg >= 5'(MASK_W))
                begin
                    k_next   = k_reg + 8'd1;
                    pos_next = pos_reg + 18'd1;
                    state_next = B_BYTE;
                end
                else if (job_reg.vmask[l_reg[1:0]])
                begin
                    state_next = B_CHK;
                end
                else
                begin
                    l_next = l_reg + 5'd1;
                end
            end
            B_CHK:
            begin
                waddr = raddr;
                if (rdata_reg != 11'd0)
                begin
                    if (!res_reg.collision)
                    begin
                        res_next.first_occupant = 10'(rdata_reg - 11'd1);
                    end
                    res_next.collision = 1'b1;
                    if (res_reg.collision_bytes != 16'hFFFF)
                    begin
                        res_next.collision_bytes = res_reg.collision_bytes + 16'd1;
                    end
                    failed_next = 1'b1;
                end
                else
                begin
                    we = 1'b1;
                    wdata = job_reg.tag;
                end
                l_next = l_reg + 5'd1;
                state_next = B_READ;
            end
            B_OUT:
            begin
                res_next.schedule_failed = failed_reg;
                if (res_valid && res_ready)
                begin
                    state_next = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= B_CLR;
            failed_reg <= 1'b0;
            clr_reg    <= '0;
            job_reg    <= '0;
            res_valid  <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            failed_reg <= failed_next;
            clr_reg    <= clr_next;
            job_reg    <= job_next;
            res_valid  <= (state_next == B_OUT);
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
        j_reg   <= j_next;
        cyc_reg <= cyc_next;
        k_reg   <= k_next;
        pos_reg <= pos_next;
        l_reg   <= l_next;
    end

    assign job_ready = (state_reg == B_IDLE);
    assign res = '{collision: res_reg.collision,
                   first_occupant: res_reg.first_occupant,
                   collision_bytes: res_reg.collision_bytes,
                   start_out_of_range: res_reg.start_out_of_range,
                   frame_out_of_range: res_reg.frame_out_of_range,
                   period_invalid: res_reg.period_invalid,
                   schedule_failed: failed_reg};

    `ASSERT_NEVER(a_write_in_range, clk, rst_n, we && state_reg == B_CHK && pos_reg >= 18'(job_reg.row))
    `ASSERT_IMPL(a_coll_fails, clk, rst_n, (res_valid && res.collision) |-> res.schedule_failed)
    `ASSERT_IMPL(a_first_cleared, clk, rst_n, (res_valid && !res.collision) |-> (res.first_occupant == 10'd0))
endmodule

FILE: rtl/slot_schedule_collision_checker.sv
// Slot schedule collision checker. In the back stage a place item walks its
// repetitions and, for each, its bytes; each of the four variant slots of a byte
// is visited in B_READ, and a selected one goes on to B_CHK for the check-and-write.
// A repetition outside the hyperperiod or a byte outside the frame row is skipped
// and flagged. A clear item sweeps the whole store, one entry a cycle; the same
// sweep runs after reset before the back stage takes the first job. The front stage
// divides the hyperperiod by the period with a serial divider and can hold the next
// item while the back stage works.
module slot_schedule_collision_checker
    import sscc_pkg::*;
#(
    parameter int MAX_VARIANTS  = MAX_VARIANTS_DEF,
    parameter int MAX_CYCLES    = MAX_CYCLES_DEF,
    parameter int MAX_ROW_BYTES = MAX_ROW_BYTES_DEF
) (
    input logic clk,
    input logic rst_n,
    sscc_cfg_if.sink       cfg,
    sscc_item_if.sink      items,
    sscc_result_if.source  results
);
    cfg_t cfg_reg;
    logic job_valid, job_ready;
    job_t job;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.slot_count    <= 10'd0;
            cfg_reg.slot_length   <= 8'd16;
            cfg_reg.hyper_period  <= 7'd64;
            cfg_reg.variant_count <= 3'd1;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_SLOT_COUNT:    cfg_reg.slot_count    <= cfg.data;
                REG_SLOT_LENGTH:   cfg_reg.slot_length   <= cfg.data[7:0];
                REG_HYPER_PERIOD:  cfg_reg.hyper_period  <= cfg.data[6:0];
                REG_VARIANT_COUNT: cfg_reg.variant_count <= cfg.data[2:0];
                default:           cfg_reg <= cfg_reg;
            endcase
        end
    end
    assign cfg.ready = 1'b1;

    sscc_front #(
        .MAX_VARIANTS(MAX_VARIANTS), .MAX_CYCLES(MAX_CYCLES), .MAX_ROW_BYTES(MAX_ROW_BYTES)
    ) u_front (
        .clk(clk), .rst_n(rst_n), .cfg(cfg_reg),
        .in_valid(items.valid), .in_ready(items.ready), .in_data(items.data),
        .job_valid(job_valid), .job_ready(job_ready), .job(job)
    );

    sscc_back #(
        .MAX_VARIANTS(MAX_VARIANTS), .MAX_CYCLES(MAX_CYCLES), .MAX_ROW_BYTES(MAX_ROW_BYTES)
    ) u_back (
        .clk(clk), .rst_n(rst_n),
        .job_valid(job_valid), .job_ready(job_ready), .job(job),
        .res_valid(results.valid), .res_ready(results.ready), .res(results.data)
    );
endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import sscc_pkg::*;

    localparam int WATCHDOG_LIMIT = 1000000;
    localparam int HOLD_CYCLES    = 3000;

    typedef struct {
        bit         is_cfg;
        logic [1:0] idx;
        logic [9:0] val;
        item_t      it;
        bit         typed;
        result_t    exp;
    } row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    sscc_cfg_if    cfg ();
    sscc_item_if   items ();
    sscc_result_if results ();

    slot_schedule_collision_checker uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg.sink),
        .items   (items.sink),
        .results (results.source)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // shadow of the block's registers and occupancy store
    cfg_t        sched;
    logic [10:0] occupancy[int];
    bit          failed_sticky;
    result_t     expected_results[$];
    int          errors = 0;
    int          idle_cycles = 0;
    bit          no_gaps = 1'b0;
    bit          hold_req = 1'b0;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 60)
            return 0;
        else if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic result_t place_signal(item_t it);
        result_t r;
        int st, cyc, reps, hp_lim, row, nv, pos, idx;
        r = '0;
        if (it.func == FUNC_CLEAR) begin
            occupancy.delete();
            failed_sticky = 1'b0;
        end else if (sched.slot_count != 0) begin
            if (it.period == 0) begin
                r.period_invalid = 1'b1;
            end else begin
                reps   = int'(sched.hyper_period) / int'(it.period);
                hp_lim = (sched.hyper_period < MAX_CYCLES_DEF) ? sched.hyper_period
                                                               : MAX_CYCLES_DEF;
                row    = int'(sched.slot_count) * int'(sched.slot_length);
                if (row > MAX_ROW_BYTES_DEF)
                    row = MAX_ROW_BYTES_DEF;
                nv     = (sched.variant_count < MAX_VARIANTS_DEF) ? sched.variant_count
                                                                  : MAX_VARIANTS_DEF;
                st     = int'($signed(it.start_cycle));
                for (int j = 0; j < reps; j++) begin
                    cyc = st + int'(it.period) * j;
                    if (cyc < 0 || cyc >= hp_lim) begin
                        r.start_out_of_range = 1'b1;
                        continue;
                    end
                    for (int k = 0; k < int'(it.byte_length); k++) begin
                        pos = int'(it.slot_index) * int'(sched.slot_length)
                              + int'(it.frame_offset) + k;
                        if (pos >= row) begin
                            r.frame_out_of_range = 1'b1;
                            continue;
                        end
                        for (int l = 0; l < nv; l++) begin
                            if (!it.variant_mask[l])
                                continue;
                            idx = (l * MAX_CYCLES_DEF + cyc) * MAX_ROW_BYTES_DEF + pos;
                            if (occupancy.exists(idx)) begin
                                if (!r.collision)
                                    r.first_occupant = 10'(occupancy[idx] - 1);
                                r.collision = 1'b1;
                                if (r.collision_bytes != 16'hFFFF)
                                    r.collision_bytes++;
                                failed_sticky = 1'b1;
                            end else begin
                                occupancy[idx] = 11'(it.signal_id) + 11'd1;
                            end
                        end
                    end
                end
            end
        end
        r.schedule_failed = failed_sticky;
        return r;
    endfunction

    function automatic item_t mk(logic f, int sig, int st, int per, int slot, int off,
                                 int len, int mask);
        item_t it;
        it.func         = f;
        it.signal_id    = 10'(sig);
        it.start_cycle  = 8'(st);
        it.period       = 7'(per);
        it.slot_index   = 10'(slot);
        it.frame_offset = 10'(off);
        it.byte_length  = 8'(len);
        it.variant_mask = 4'(mask);
        return it;
    endfunction

    // mostly well-formed placements inside the current frame row
    function automatic item_t random_item();
        int hp, sl, sc, per, r;
        hp  = (sched.hyper_period == 0) ? 1 : sched.hyper_period;
        sl  = (sched.slot_length == 0) ? 1 : sched.slot_length;
        sc  = (sched.slot_count == 0) ? 1 : sched.slot_count;
        r   = $urandom_range(0, 99);
        per = $urandom_range((hp / 4 > 0) ? hp / 4 : 1, hp);
        if (r < 85)
            return mk(FUNC_PLACE, $urandom_range(0, 1023), $urandom_range(0, per - 1), per,
                      $urandom_range(0, (sc < 8) ? sc - 1 : 7),
                      $urandom_range(0, (sl < 4) ? sl - 1 : 3),
                      $urandom_range(1, 4), $urandom_range(0, 15));
        else if (r < 97)
            return mk(FUNC_PLACE, $urandom_range(0, 1023), $urandom_range(0, 255) - 128,
                      $urandom_range(0, 64), $urandom_range(0, 1023),
                      $urandom_range(0, 1023), $urandom_range(0, 8), $urandom_range(0, 15));
        // rare long signal, single repetition
        return mk(FUNC_PLACE, $urandom_range(0, 1023), 0, hp, 0, $urandom_range(0, 20),
                  $urandom_range(100, 255), $urandom_range(1, 3));
    endfunction

    task automatic report(string what, int got, int exp);
        $display("mismatch %s: got %0d expected %0d", what, got, exp);
        errors++;
    endtask

    task automatic send_item(item_t it, bit typed, result_t typed_exp);
        int g;
        result_t pred;
        g = pick_gap();
        @(negedge clk);
        if (g > 0) begin
            items.valid <= 1'b0;
            repeat (g) @(negedge clk);
        end
        items.valid <= 1'b1;
        items.data  <= it;
        do @(posedge clk); while (!items.ready);
        pred = place_signal(it);
        expected_results.push_back(typed ? typed_exp : pred);
    endtask

    task automatic wait_idle();
        @(negedge clk);
        items.valid <= 1'b0;
        while (expected_results.size() != 0)
            @(negedge clk);
        repeat (30) @(negedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [9:0] val);
        @(negedge clk);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= val;
        do @(posedge clk); while (!cfg.ready);
        case (idx)
            REG_SLOT_COUNT:    sched.slot_count    = val[9:0];
            REG_SLOT_LENGTH:   sched.slot_length   = val[7:0];
            REG_HYPER_PERIOD:  sched.hyper_period  = val[6:0];
            REG_VARIANT_COUNT: sched.variant_count = val[2:0];
            default: ;
        endcase
        @(negedge clk);
        cfg.valid <= 1'b0;
    endtask

    task automatic set_schedule(int sc, int sl, int hp, int vc);
        write_reg(REG_SLOT_COUNT, 10'(sc));
        write_reg(REG_SLOT_LENGTH, 10'(sl));
        write_reg(REG_HYPER_PERIOD, 10'(hp));
        write_reg(REG_VARIANT_COUNT, 10'(vc));
    endtask

    // result checking
    always @(posedge clk)
    begin
        if (rst_n && results.valid && results.ready) begin
            if (expected_results.size() == 0) begin
                $display("result beat with nothing expected");
                errors++;
            end else begin
                result_t e, g;
                e = expected_results.pop_front();
                g = results.data;
                if (g.collision !== e.collision)
                    report("collision", g.collision, e.collision);
                if (g.first_occupant !== e.first_occupant)
                    report("first_occupant", g.first_occupant, e.first_occupant);
                if (g.collision_bytes !== e.collision_bytes)
                    report("collision_bytes", g.collision_bytes, e.collision_bytes);
                if (g.start_out_of_range !== e.start_out_of_range)
                    report("start_out_of_range", g.start_out_of_range, e.start_out_of_range);
                if (g.frame_out_of_range !== e.frame_out_of_range)
                    report("frame_out_of_range", g.frame_out_of_range, e.frame_out_of_range);
                if (g.period_invalid !== e.period_invalid)
                    report("period_invalid", g.period_invalid, e.period_invalid);
                if (g.schedule_failed !== e.schedule_failed)
                    report("schedule_failed", g.schedule_failed, e.schedule_failed);
            end
        end
    end

    // result side back-pressure
    initial
    begin
        int stall;
        stall = 0;
        results.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_req) begin
                results.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_req = 1'b0;
            end else if (stall > 0) begin
                results.ready <= 1'b0;
                stall--;
            end else begin
                results.ready <= 1'b1;
                stall = pick_gap();
            end
        end
    end

    always @(posedge clk)
    begin
        if ((items.valid && items.ready) || (results.valid && results.ready)
            || (cfg.valid && cfg.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial
    begin
        row_t    rows[$];
        result_t zero_res, perinv_res;
        int      phase_cfg[5][4];
        zero_res   = '0;
        perinv_res = '0;
        perinv_res.period_invalid = 1'b1;
        phase_cfg = '{'{1023, 254, 64, 4}, '{1, 1, 1, 1}, '{16, 8, 32, 2},
                      '{5, 200, 48, 3}, '{0, 16, 64, 1}};

        items.valid = 1'b0;
        items.data  = '0;
        cfg.valid   = 1'b0;
        cfg.index   = REG_SLOT_COUNT;
        cfg.data    = '0;
        sched.slot_count    = 10'd0;
        sched.slot_length   = 8'd16;
        sched.hyper_period  = 7'd64;
        sched.variant_count = 3'd1;
        failed_sticky = 1'b0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: no schedule, then a small row with all four variants
        rows.push_back('{0, 0, 0, mk(FUNC_PLACE, 3, 0, 8, 0, 0, 2, 15), 1, zero_res});
        rows.push_back('{1, REG_SLOT_COUNT, 10'd8, '0, 0, '0});
        rows.push_back('{1, REG_VARIANT_COUNT, 10'd4, '0, 0, '0});
        rows.push_back('{0, 0, 0, mk(FUNC_PLACE, 3, 0, 0, 0, 0, 2, 15), 1, perinv_res});
        rows.push_back('{0, 0, 0, mk(FUNC_PLACE, 5, 0, 64, 0, 0, 4, 15), 0, '0});
        rows.push_back('{0, 0, 0, mk(FUNC_PLACE, 1023, 0, 64, 0, 2, 4, 1), 0, '0});
        rows.push_back('{0, 0, 0, mk(FUNC_PLACE, 7, -64, 64, 1, 0, 2, 15), 0, '0});
        rows.push_back('{0, 0, 0, mk(FUNC_PLACE, 8, 127, 1, 1, 0, 1, 15), 0, '0});
        rows.push_back('{0, 0, 0, mk(FUNC_PLACE, 9, 0, 1, 2, 0, 1, 3), 0, '0});
        rows.push_back('{0, 0, 0, mk(FUNC_PLACE, 10, 3, 64, 1023, 1023, 255, 15), 0, '0});
        rows.push_back('{0, 0, 0, mk(FUNC_PLACE, 11, 0, 64, 7, 10, 10, 15), 0, '0});
        rows.push_back('{0, 0, 0, mk(FUNC_PLACE, 12, 0, 64, 3, 0, 0, 15), 0, '0});
        rows.push_back('{0, 0, 0, mk(FUNC_PLACE, 13, 0, 64, 3, 0, 4, 0), 0, '0});
        rows.push_back('{0, 0, 0, mk(FUNC_PLACE, 14, 60, 33, 4, 5, 3, 6), 0, '0});
        rows.push_back('{0, 0, 0, mk(FUNC_PLACE, 15, 0, 65, 4, 0, 3, 15), 0, '0});
        rows.push_back('{0, 0, 0, mk(FUNC_CLEAR, 1023, -1, 127, 1023, 1023, 255, 15),
                         1, zero_res});
        rows.push_back('{0, 0, 0, mk(FUNC_PLACE, 1023, 0, 64, 0, 0, 4, 15), 0, '0});
        rows.push_back('{0, 0, 0, mk(FUNC_PLACE, 0, 0, 64, 0, 0, 4, 15), 0, '0});

        foreach (rows[i]) begin
            if (rows[i].is_cfg) begin
                wait_idle();
                write_reg(rows[i].idx, rows[i].val);
            end else begin
                send_item(rows[i].it, rows[i].typed, rows[i].exp);
            end
        end

        for (int p = 0; p < 5; p++) begin
            wait_idle();
            set_schedule(phase_cfg[p][0], phase_cfg[p][1], phase_cfg[p][2], phase_cfg[p][3]);
            no_gaps  = (p == 2);
            hold_req = (p == 0);
            repeat ((p == 4) ? 40 : 115)
                send_item(random_item(), 1'b0, '0);
        end

        wait_idle();
        repeat (50) @(negedge clk);
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule
